FILE: hw/rtl/markup_escape_sanitizer_defines.svh
// ----------------------------------------------------------------------------
// markup_escape_sanitizer_defines
// Assertion helpers for the markup escape sanitizer.
// ----------------------------------------------------------------------------
`ifndef MARKUP_ESCAPE_SANITIZER_DEFINES_SVH
`define MARKUP_ESCAPE_SANITIZER_DEFINES_SVH
// Assert a property on every clock edge outside reset.
`define MES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Assert a property that must also hold during reset.
`define MES_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

FILE: hw/rtl/mes_pkg.sv
// ----------------------------------------------------------------------------
// mes_pkg
// Shared constants and types for the markup escape sanitizer.
// ----------------------------------------------------------------------------
package mes_pkg;
  localparam int unsigned Lookahead = 132;
  localparam int unsigned StepLimit = 16384;
  localparam int unsigned FillW = $clog2(Lookahead + 1);
  localparam int unsigned StepW = $clog2(StepLimit + 1);
  localparam int unsigned KeyMax = 63;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChOpen   = 8'h28;
  localparam logic [7:0] ChClose  = 8'h29;
  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChH      = 8'h48;
  localparam logic [7:0] ChI      = 8'h49;
  localparam logic [7:0] ChB      = 8'h42;
  localparam logic [7:0] ChSeven  = 8'h37;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDel    = 8'h7F;
  localparam logic [7:0] LenLimit = 8'h80;

  // Per-position window flags handed from the flag stage to the decide stage.
  typedef struct packed {
    logic interp_bad;
    logic embed_bad;
    logic block_bad;
  } win_flags_t;
endpackage

FILE: hw/rtl/mes_window.sv
// ----------------------------------------------------------------------------
// mes_window
// Parallel window checks over the delay line for the byte at its head.
// ----------------------------------------------------------------------------
module mes_window (
  input  logic [mes_pkg::Lookahead*8-1:0] line_i,
  output mes_pkg::win_flags_t             flags_o
);
  logic [7:0] c [mes_pkg::Lookahead];
  logic [mes_pkg::Lookahead-1:0] is_zero, is_close, is_caret, is_bad;

  // Classify every byte of the line.
  always_comb begin
    for (int i = 0; i < mes_pkg::Lookahead; i++) begin
      c[i] = line_i[i*8 +: 8];
      is_zero[i]  = (c[i] == 8'd0);
      is_close[i] = (c[i] == mes_pkg::ChClose);
      is_caret[i] = (c[i] == mes_pkg::ChCaret);
      is_bad[i]   = (c[i] < mes_pkg::ChSpace) || (c[i] >= mes_pkg::ChDel);
    end
  end

  // '$(' check: first zero or ')' in the 64 bytes after '('.
  always_comb begin
    logic found, res;
    found = 1'b0;
    res = 1'b1;
    for (int k = 0; k <= mes_pkg::KeyMax; k++) begin
      if (!found && (is_zero[2+k] || is_close[2+k])) begin
        found = 1'b1;
        res = is_zero[2+k] || (k == 0);
      end
    end
    flags_o.interp_bad = res;
  end

  // '^B' check: a '^' must come before any zero within 63 bytes.
  always_comb begin
    logic found, res;
    found = 1'b0;
    res = 1'b1;
    for (int n = 0; n < mes_pkg::KeyMax; n++) begin
      if (!found && (is_zero[1+n] || is_caret[1+n])) begin
        found = 1'b1;
        res = is_zero[1+n];
      end
    end
    flags_o.block_bad = res;
  end

  // '^H'/'^I' check: length bytes must be nonzero and printable.
  always_comb begin
    logic [7:0] len;
    logic run_bad;
    len = c[3];
    run_bad = 1'b0;
    for (int a = 0; a < 127; a++) begin
      if (8'(a) < len && (is_zero[4+a] || is_bad[4+a])) run_bad = 1'b1;
    end
    flags_o.embed_bad = is_zero[1] || is_zero[2] || is_zero[3] ||
                        (len >= mes_pkg::LenLimit) || run_bad;
  end
endmodule

FILE: hw/rtl/markup_escape_sanitizer.sv
// ----------------------------------------------------------------------------
// markup_escape_sanitizer
// Streaming sanitizer for zero-terminated markup with a lookahead line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one byte per item. Output
//   channel out_valid_o/out_ready_i carries the byte leaving the line with
//   its replaced, end-of-string and string-flagged bits.
//   The first 131 items fill the line and give no result; every later item
//   gives exactly one result. Feed zeros to flush the tail of the stream.
//   Throughput is one item per cycle while in_ready_o is high; the window checks
//   are one level of parallel reductions between the line register and the
//   result register, so a result is registered as its item is accepted.
//   A skid register lets the input keep flowing for one item while the
//   receiver stalls; with both result and skid full, in_ready_o drops.
//   Reset clears the line to zeros, the scan state and the result path,
//   and sets enable to 1. Write enable through cfg_we_i/cfg_wdata_i only
//   while idle.
// ----------------------------------------------------------------------------
`include "markup_escape_sanitizer_defines.svh"
module markup_escape_sanitizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       was_replaced_o,
  output logic       end_of_string_o,
  output logic       string_flagged_o
);
  localparam int unsigned L = mes_pkg::Lookahead;

  typedef struct packed {
    logic [7:0] b;
    logic       repl;
    logic       eos;
    logic       flg;
  } res_t;

  logic [L*8-1:0] line_q, line_d, line_shift;
  logic [mes_pkg::FillW-1:0] fill_q;
  logic skip_q, hit_q, stop_q, en_q;
  logic [mes_pkg::StepW-1:0] step_q;
  res_t out_q, skid_q, res;
  logic out_v_q, skid_v_q, accept, full, produce;
  mes_pkg::win_flags_t flags;

  mes_window u_win (.line_i(line_shift), .flags_o(flags));

  assign in_ready_o = !skid_v_q;
  assign accept = in_valid_i && in_ready_o;
  assign full = (fill_q == mes_pkg::FillW'(L - 1));
  assign produce = accept && full;

  // Place the new byte in the line; head is byte 0.
  always_comb begin
    line_shift = line_q;
    for (int i = 0; i < L; i++) begin
      if (mes_pkg::FillW'(i) == fill_q) line_shift[i*8 +: 8] = in_byte_i;
    end
    line_d = {8'd0, line_shift[L*8-1:8]};
  end

  // Judge the head byte.
  logic [7:0] hb, h1;
  logic skip_d, hit_d, stop_d;
  logic [mes_pkg::StepW-1:0] step_d;
  always_comb begin
    hb = line_shift[7:0];
    h1 = line_shift[15:8];
    res = '{b: hb, repl: 1'b0, eos: 1'b0, flg: 1'b0};
    skip_d = skip_q; hit_d = hit_q; stop_d = stop_q; step_d = step_q;
    if (hb == 8'd0) begin
      res.eos = 1'b1;
      res.flg = hit_q;
      skip_d = 1'b0; step_d = '0; hit_d = 1'b0; stop_d = 1'b0;
    end else if (!en_q || stop_q) begin
    end else if (skip_q) begin
      skip_d = 1'b0;
      if (hb == mes_pkg::ChH || hb == mes_pkg::ChI) res.repl = flags.embed_bad;
      else if (hb == mes_pkg::ChB) res.repl = flags.block_bad;
      if (res.repl) res.b = mes_pkg::ChSeven;
    end else if (step_q >= mes_pkg::StepW'(mes_pkg::StepLimit)) begin
      stop_d = 1'b1;
    end else begin
      step_d = step_q + 1'b1;
      if (hb == mes_pkg::ChDollar && h1 == mes_pkg::ChOpen) begin
        if (flags.interp_bad) begin
          res.repl = 1'b1;
          res.b = mes_pkg::ChSpace;
        end
      end else if (hb == mes_pkg::ChCaret && h1 != 8'd0) begin
        skip_d = 1'b1;
      end
    end
    if (res.repl) hit_d = 1'b1;
  end

  // Advance line, scan state and the output/skid pair.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0; fill_q <= '0; skip_q <= 1'b0; hit_q <= 1'b0;
      stop_q <= 1'b0; step_q <= '0; en_q <= 1'b1;
      out_v_q <= 1'b0; skid_v_q <= 1'b0; out_q <= '0; skid_q <= '0;
    end else begin
      if (cfg_we_i) en_q <= cfg_wdata_i;
      if (accept) begin
        if (full) begin
          line_q <= line_d;
          skip_q <= skip_d; hit_q <= hit_d; stop_q <= stop_d; step_q <= step_d;
        end else begin
          line_q <= line_shift;
          fill_q <= fill_q + 1'b1;
        end
      end
      if (!out_v_q || out_ready_i) begin
        if (skid_v_q) begin
          out_q <= skid_q; out_v_q <= 1'b1; skid_v_q <= 1'b0;
        end else begin
          out_q <= res; out_v_q <= produce;
        end
        if (skid_v_q && produce) begin
          skid_q <= res; skid_v_q <= 1'b1;
        end
      end else if (produce) begin
        skid_q <= res; skid_v_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_byte_o = out_q.b;
  assign was_replaced_o = out_q.repl;
  assign end_of_string_o = out_q.eos;
  assign string_flagged_o = out_q.flg;

  `MES_ASSERT(a_skid_needs_out, skid_v_q |-> out_v_q, "skid full while output empty")
  `MES_ASSERT(a_eos_zero, (out_v_q && out_q.eos) |-> (out_q.b == 8'd0), "terminator not zero")
  `MES_ASSERT(a_flag_on_eos, (out_v_q && out_q.flg) |-> out_q.eos, "flag off terminator")
  `MES_ASSERT_ALWAYS(a_fill_range, fill_q <= mes_pkg::FillW'(L - 1), "fill count overflow")
endmodule
